[rtl/ncc_pkg.sv]
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared constants and types for the normalized cross-correlation stereo block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_KERNEL = 16;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [4:0]  RST_KERNEL_SIZE  = 5'd5;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;

  typedef struct packed {
    logic done;
    logic greater;
  } ncc_cmp_stat_t;

endpackage

`default_nettype wire

[rtl/ncc_ram.sv]
// ----------------------------------------------------------------------------
// ncc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/ncc_mac.sv]
// ----------------------------------------------------------------------------
// ncc_mac
// Window accumulator: cross product and candidate energy, one pair per acc cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_mac import ncc_pkg::*; #(
  parameter int NW = 24
) (
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             acc,
  input  wire logic [PIX_W-1:0] t,
  input  wire logic [PIX_W-1:0] v,
  output logic      [NW-1:0]    num,
  output logic      [NW-1:0]    en
);

  logic [NW-1:0]      num_r;
  logic [NW-1:0]      en_r;
  logic [2*PIX_W-1:0] tv;
  logic [2*PIX_W-1:0] vv;

  assign tv = t * v;
  assign vv = v * v;

  always_ff @(posedge clk) begin
    if (clr) begin
      num_r <= '0;
      en_r  <= '0;
    end else if (acc) begin
      num_r <= num_r + NW'(tv);
      en_r  <= en_r + NW'(vv);
    end
  end

  assign num = num_r;
  assign en  = en_r;

endmodule

`default_nettype wire

[rtl/ncc_cmp.sv]
// ----------------------------------------------------------------------------
// ncc_cmp
// Score compare: num^2*best_en against best_num^2*en on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_cmp import ncc_pkg::*; #(
  parameter int NW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [NW-1:0] en,
  input  wire logic [NW-1:0] best_num,
  input  wire logic [NW-1:0] best_en,
  output ncc_cmp_stat_t      stat
);

  logic [2:0]      step_r;
  logic            busy_r;
  logic            done_r;
  logic            gt_r;
  logic [NW-1:0]   a;
  logic [NW-1:0]   b;
  logic [2*NW-1:0] prod;
  logic [2*NW-1:0] sq_r;
  logic [2*NW-1:0] lo_r;
  logic [3*NW-1:0] l1_r;
  logic [3*NW-1:0] l2_r;
  logic [3*NW-1:0] wide;

  always_comb begin
    unique case (step_r)
      3'd0:    begin a = num;               b = num;      end
      3'd1:    begin a = sq_r[NW-1:0];      b = best_en;  end
      3'd2:    begin a = sq_r[2*NW-1:NW];   b = best_en;  end
      3'd3:    begin a = best_num;          b = best_num; end
      3'd4:    begin a = sq_r[NW-1:0];      b = en;       end
      3'd5:    begin a = sq_r[2*NW-1:NW];   b = en;       end
      default: begin a = '0;                b = '0;       end
    endcase
  end

  assign prod = a * b;
  assign wide = {prod, {NW{1'b0}}} + {{NW{1'b0}}, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        unique case (step_r)
          3'd0, 3'd3: sq_r <= prod;
          3'd1, 3'd4: lo_r <= prod;
          3'd2:       l1_r <= wide;
          3'd5:       l2_r <= wide;
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
            gt_r   <= l1_r > l2_r;
          end
        endcase
      end
    end
  end

  assign stat.done    = done_r;
  assign stat.greater = gt_r;

endmodule

`default_nettype wire

[rtl/ncc_stereo_disparity.sv]
// ----------------------------------------------------------------------------
// ncc_stereo_disparity
// Block-matching stereo disparity by normalized cross-correlation.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  in_left_pixel, in_right_pixel
//   out      output     out_valid/out_ready out_row, out_column, out_disparity,
//                                          out_frame_last
//   cfg      input      cfg_we             cfg_index, cfg_wdata
//
// a pixel in the first K rows gives no item
// a pixel with no search goes straight to output; a search tries
//   W-j-K candidates, one line-store read per cycle while accumulating
// each candidate with nonzero energy is compared on a shared multiplier
// a finished item waits in the output register while the next is taken
// reset is synchronous; line stores need no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_stereo_disparity import ncc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_left_pixel,
  input  wire logic [PIX_W-1:0]     in_right_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [POS_W-1:0]     out_row,
  output logic      [POS_W-1:0]     out_column,
  output logic      [PIX_W-1:0]     out_disparity,
  output logic                      out_frame_last,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int ROWS  = MAX_KERNEL + 1;
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(ROWS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int NW    = $clog2(MAX_KERNEL * MAX_KERNEL * 65025 + 1);
  localparam int DW    = (CW > PIX_W) ? CW : PIX_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ACC   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_CHK   = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t          state_r;
  logic [4:0]      kernel_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [KW-1:0]   k_eff;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  logic [RW-1:0]   row_r;
  logic [CW-1:0]   col_r;
  logic [SW-1:0]   slot_r;

  logic [RW-1:0]   i_r;
  logic [CW-1:0]   j_r;
  logic            last_r;
  logic [CW-1:0]   cand_r;
  logic [KW-1:0]   r_r;
  logic [KW-1:0]   c_r;
  logic [SW-1:0]   rslot_r;
  logic [SW-1:0]   tslot_r;
  logic            rv_r;
  logic [NW-1:0]   best_num_r;
  logic [NW-1:0]   best_en_r;
  logic [CW-1:0]   best_d_r;

  logic            out_valid_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  logic [PIX_W-1:0] out_disp_r;
  logic            out_last_r;

  logic            accept;
  logic            has_out;
  logic            search;
  logic            frame_end;
  logic [SW:0]     ts_sum;
  logic [SW-1:0]   top_slot;
  logic [WW:0]     col1;
  logic [HW:0]     row1;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   laddr;
  logic [AW-1:0]   raddr;
  logic [PIX_W-1:0] l_rd;
  logic [PIX_W-1:0] r_rd;
  logic [NW-1:0]   mac_num;
  logic [NW-1:0]   mac_en;
  logic            acc_clr;
  logic            cmp_start;
  logic            adv;
  logic            cand_last;
  logic            issue;
  logic [DW-1:0]   disp_ext;
  ncc_cmp_stat_t   cmp_stat;

  always_comb begin
    if (kernel_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(kernel_r) > MAX_KERNEL) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(kernel_r);
    end
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign has_out   = 32'(row_r) >= 32'(k_eff);
  assign search    = (32'(col_r) + 32'(k_eff)) < 32'(w_eff);
  assign frame_end = (32'(row_r) + 1 >= 32'(h_eff)) && (32'(col_r) + 1 >= 32'(w_eff));
  assign ts_sum    = (SW+1)'(slot_r) + (SW+1)'(ROWS) - (SW+1)'(k_eff);
  assign top_slot  = (32'(ts_sum) >= ROWS) ? SW'(32'(ts_sum) - ROWS) : SW'(ts_sum);
  assign col1      = (WW+1)'(col_r) + (WW+1)'(1);
  assign row1      = (HW+1)'(row_r) + (HW+1)'(1);

  assign waddr = AW'(32'(slot_r) * MAX_WIDTH + 32'(col_r));
  assign laddr = AW'(32'(rslot_r) * MAX_WIDTH + 32'(j_r) + 32'(c_r));
  assign raddr = AW'(32'(rslot_r) * MAX_WIDTH + 32'(cand_r) + 32'(c_r));

  assign issue     = (state_r == ST_ACC);
  assign cand_last = (32'(cand_r) + 32'(k_eff) + 1) >= 32'(w_eff);
  assign cmp_start = (state_r == ST_CHK) && (mac_en != '0);
  assign adv       = ((state_r == ST_CHK) && (mac_en == '0)) ||
                     ((state_r == ST_CMP) && cmp_stat.done);
  assign acc_clr   = (accept && has_out && search) || (adv && !cand_last);

  ncc_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (in_left_pixel),
    .raddr (laddr),
    .rdata (l_rd)
  );

  ncc_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (in_right_pixel),
    .raddr (raddr),
    .rdata (r_rd)
  );

  ncc_mac #(.NW(NW)) u_mac (
    .clk (clk),
    .clr (acc_clr),
    .acc (rv_r),
    .t   (l_rd),
    .v   (r_rd),
    .num (mac_num),
    .en  (mac_en)
  );

  ncc_cmp #(.NW(NW)) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmp_start),
    .num      (mac_num),
    .en       (mac_en),
    .best_num (best_num_r),
    .best_en  (best_en_r),
    .stat     (cmp_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kernel_r    <= RST_KERNEL_SIZE;
      width_r     <= RST_IMAGE_WIDTH;
      height_r    <= RST_IMAGE_HEIGHT;
      row_r       <= '0;
      col_r       <= '0;
      slot_r      <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= issue;
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (32'(col1) >= 32'(w_eff)) begin
              col_r <= '0;
              if (32'(row1) >= 32'(h_eff)) begin
                row_r  <= '0;
                slot_r <= '0;
              end else begin
                row_r  <= RW'(row1);
                slot_r <= (32'(slot_r) == ROWS - 1) ? '0 : slot_r + SW'(1);
              end
            end else begin
              col_r <= CW'(col1);
            end
            i_r        <= row_r - RW'(k_eff);
            j_r        <= col_r;
            cand_r     <= col_r;
            last_r     <= frame_end;
            r_r        <= '0;
            c_r        <= '0;
            rslot_r    <= top_slot;
            tslot_r    <= top_slot;
            best_num_r <= '0;
            best_en_r  <= NW'(1);
            best_d_r   <= '0;
            if (has_out) begin
              state_r <= search ? ST_ACC : ST_OUT;
            end
          end
        end
        ST_ACC: begin
          if (c_r == k_eff - KW'(1)) begin
            c_r <= '0;
            if (r_r == k_eff - KW'(1)) begin
              state_r <= ST_DRAIN;
            end else begin
              r_r     <= r_r + KW'(1);
              rslot_r <= (32'(rslot_r) == ROWS - 1) ? '0 : rslot_r + SW'(1);
            end
          end else begin
            c_r <= c_r + KW'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (cmp_start) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (cmp_stat.done && cmp_stat.greater) begin
            best_num_r <= mac_num;
            best_en_r  <= mac_en;
            best_d_r   <= cand_r - j_r;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_row_r   <= POS_W'(i_r);
            out_col_r   <= POS_W'(j_r);
            out_disp_r  <= disp_ext[PIX_W-1:0];
            out_last_r  <= last_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (adv) begin
        if (cand_last) begin
          state_r <= ST_OUT;
        end else begin
          cand_r  <= cand_r + CW'(1);
          r_r     <= '0;
          c_r     <= '0;
          rslot_r <= tslot_r;
          state_r <= ST_ACC;
        end
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KERNEL_SIZE: begin
            kernel_r <= cfg_wdata[4:0];
            row_r    <= '0;
            col_r    <= '0;
            slot_r   <= '0;
          end
          CFG_IMAGE_WIDTH: begin
            width_r <= cfg_wdata;
            row_r   <= '0;
            col_r   <= '0;
            slot_r  <= '0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_r <= cfg_wdata;
            row_r    <= '0;
            col_r    <= '0;
            slot_r   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign disp_ext       = DW'(best_d_r);
  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_column     = out_col_r;
  assign out_disparity  = out_disp_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

[rtl/ncc_chk.sv]
// ----------------------------------------------------------------------------
// ncc_chk
// Port-level checks for the stereo disparity block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_chk import ncc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [POS_W-1:0] out_row,
  input wire logic [POS_W-1:0] out_column,
  input wire logic [PIX_W-1:0] out_disparity,
  input wire logic             out_frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_column)
      && $stable(out_disparity) && $stable(out_frame_last))
    else $error("output item changed while stalled");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("output item loaded while input side idle");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

  a_keep_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> out_valid)
    else $error("waiting output item lost on input accept");

endmodule

bind ncc_stereo_disparity ncc_chk u_ncc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_row        (out_row),
  .out_column     (out_column),
  .out_disparity  (out_disparity),
  .out_frame_last (out_frame_last)
);

`default_nettype wire
